/* rtl/cmdkw_pkg.sv */
// ----------------------------------------------------------------------------
// Command keyword matcher package
// Shared constants, keyword table, phase and prefix codes, byte helpers.
// ----------------------------------------------------------------------------
package cmdkw_pkg;

    localparam int unsigned LINE_MAX      = 128;
    localparam int unsigned PREFIX_MAX    = 32;
    localparam int unsigned KEYWORD_COUNT = 7;
    localparam int unsigned KW_MAX_LEN    = 25;

    localparam int unsigned KW_IDX_W   = $clog2(KW_MAX_LEN);
    localparam int unsigned LINE_POS_W = $clog2(LINE_MAX + 1);
    localparam int unsigned KW_START_W = $clog2(LINE_MAX);
    localparam int unsigned KW_TEXT_W  = 8 * KW_MAX_LEN;

    localparam logic [2:0] CMD_NO_MATCH = 3'd7;

    // special bytes
    localparam logic [7:0] CH_ABORT   = 8'h03;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_AT      = 8'h40;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PIPE    = 8'h7C;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LOWER_P = 8'h70;
    localparam logic [7:0] CH_LOWER_S = 8'h73;

    typedef enum logic [2:0] {
        PH_SCAN,
        PH_FOLLOW,
        PH_HEX1,
        PH_HEX2,
        PH_MATCH,
        PH_MATCH_CS,
        PH_FAIL,
        PH_HEX2_BAD
    } kw_phase_t;

    typedef enum logic [2:0] {
        PFX_NONE,
        PFX_RECEIVED,
        PFX_TOO_LONG,
        PFX_TOO_SHORT,
        PFX_UNKNOWN
    } prefix_status_t;

    // keyword text, right-justified: last character in the low byte
    localparam logic [KW_TEXT_W-1:0] KW_TEXT [KEYWORD_COUNT] = '{
        KW_TEXT_W'("print,/par/pwr/bat/a"),
        KW_TEXT_W'("print,/par/rcv/ver/pwr/sn"),
        KW_TEXT_W'("print,/par/rcv/ver/pwr/fw"),
        KW_TEXT_W'("print,/par/rcv/ver/pwr/hw"),
        KW_TEXT_W'({"set,/par/gr", "i3/bl"}),
        KW_TEXT_W'({"set,/par/gr", "i3/dbg,off"}),
        KW_TEXT_W'({"set,/par/gr", "i3/dbg,on"})
    };

    localparam logic [KW_IDX_W-1:0] KW_LEN [KEYWORD_COUNT] = '{
        KW_IDX_W'(20), KW_IDX_W'(25), KW_IDX_W'(25), KW_IDX_W'(25),
        KW_IDX_W'(16), KW_IDX_W'(21), KW_IDX_W'(20)
    };

    function automatic logic [7:0] rotl2(input logic [7:0] v);
        return {v[5:0], v[7:6]};
    endfunction

    // 0..15 for a hex digit, 16 otherwise
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] d;
        d = 5'd16;
        if (c inside {[8'h30:8'h39]}) begin
            d = 5'(c - 8'h30);
        end else if (c inside {[8'h41:8'h46]}) begin
            d = 5'(c - 8'h37);
        end else if (c inside {[8'h61:8'h66]}) begin
            d = 5'(c - 8'h57);
        end
        return d;
    endfunction

    function automatic logic [7:0] kw_char(input int unsigned k,
                                           input logic [KW_IDX_W-1:0] idx);
        logic [KW_IDX_W-1:0] pos;
        pos = KW_LEN[k] - idx - KW_IDX_W'(1);
        return KW_TEXT[k][{pos, 3'b000} +: 8];
    endfunction

endpackage

/* rtl/command_line_keyword_matcher_core.sv */
// ----------------------------------------------------------------------------
// Command line keyword matcher core
// Splits a byte stream into lines and reports the command keyword per line.
// ----------------------------------------------------------------------------
// One byte word is taken per cycle, back to back, and each line closes with a
// one-word result in the cycle after its terminator is accepted; the seven
// keyword matchers and the rotate-XOR line checksum all step together on the
// accepted byte, and a single result register holds the line summary.  CR or
// LF ends a line; terminators with no line open (runs, empty lines) give no
// word, and 0x03 throws the current line away silently.  A keyword counts only
// when followed by @ ; & | space or the terminator; after '@' two hex digits
// must match the checksum over the line up to and including the '@', rotated
// left two bits (bad or missing digits read as 0xFF).  The result carries the
// lowest-index matching keyword (7 for none), whether a checksum verified,
// the %...% prefix status and length, the line length saturated at LINE_MAX
// and an overflow flag; an overflowed line, or one not starting with p, s or
// %, never reports a keyword.  Bytes that close no line keep flowing while a
// result word waits; s_ready drops only for a terminator that would close a
// line while a result word is held and m_ready is low.
// ----------------------------------------------------------------------------
module command_line_keyword_matcher_core
    import cmdkw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_command_index,
    output logic       m_checksum_present,
    output logic [2:0] m_prefix_status,
    output logic [4:0] m_prefix_length,
    output logic [7:0] m_line_length,
    output logic       m_line_overflow
);

    // ---------------- line state ----------------
    logic [LINE_POS_W-1:0] line_pos_reg,  line_pos_next;
    logic                  in_line_reg,   in_line_next;
    logic                  first_ok_reg,  first_ok_next;
    logic                  first_pct_reg, first_pct_next;
    logic [7:0]            csum_reg,      csum_next;
    logic                  ovf_reg,       ovf_next;
    logic                  prev_pct_reg,  prev_pct_next;

    // ---------------- per-keyword state ----------------
    logic [KW_IDX_W-1:0]   kw_prog_reg  [KEYWORD_COUNT];
    logic [KW_IDX_W-1:0]   kw_prog_next [KEYWORD_COUNT];
    logic [KW_START_W-1:0] kw_start_reg  [KEYWORD_COUNT];
    logic [KW_START_W-1:0] kw_start_next [KEYWORD_COUNT];
    kw_phase_t             kw_phase_reg  [KEYWORD_COUNT];
    kw_phase_t             kw_phase_next [KEYWORD_COUNT];
    logic [7:0]            kw_snap_reg  [KEYWORD_COUNT];
    logic [7:0]            kw_snap_next [KEYWORD_COUNT];
    logic [3:0]            kw_wr_reg  [KEYWORD_COUNT];   // first hex digit
    logic [3:0]            kw_wr_next [KEYWORD_COUNT];
    logic                  kw_plp_reg  [KEYWORD_COUNT];  // '%' just before start
    logic                  kw_plp_next [KEYWORD_COUNT];

    // phase each matcher would settle in if the line ended now
    kw_phase_t             kw_end_phase [KEYWORD_COUNT];
    logic [KEYWORD_COUNT-1:0] kw_hit;

    // ---------------- result register ----------------
    logic                  m_valid_reg, m_valid_next;
    logic [2:0]            cmd_reg,  cmd_next;
    logic                  cs_reg,   cs_next;
    prefix_status_t        pst_reg,  pst_next;
    logic [4:0]            plen_reg, plen_next;
    logic [7:0]            llen_reg;
    logic                  lovf_reg;

    logic       accept;
    logic       is_abort;
    logic       is_term;
    logic       emit;
    logic       byte_go;       // ordinary byte that enters the line
    logic [7:0] csum_upd;
    logic [4:0] hex_d;

    // hit selection
    logic [2:0]            hit_idx;
    logic                  hit_any;
    logic [KW_START_W-1:0] hit_start;

    // only a line-closing terminator needs the result register free
    assign s_ready  = !m_valid_reg || m_ready || !emit;
    assign accept   = s_valid && s_ready;
    assign is_abort = (s_data_byte == CH_ABORT);
    assign is_term  = (s_data_byte == CH_LF) || (s_data_byte == CH_CR);
    assign emit     = is_term && in_line_reg;
    assign byte_go  = !is_abort && !is_term && !ovf_reg
                      && (line_pos_reg < LINE_POS_W'(LINE_MAX));
    assign csum_upd = rotl2(csum_reg) ^ s_data_byte;
    assign hex_d    = hex_value(s_data_byte);

    // ---------------- line bookkeeping ----------------
    always_comb begin
        line_pos_next  = line_pos_reg;
        in_line_next   = in_line_reg;
        first_ok_next  = first_ok_reg;
        first_pct_next = first_pct_reg;
        csum_next      = csum_reg;
        ovf_next       = ovf_reg;
        prev_pct_next  = prev_pct_reg;
        if (accept) begin
            if (is_abort || is_term) begin
                line_pos_next  = '0;
                in_line_next   = 1'b0;
                first_ok_next  = 1'b0;
                first_pct_next = 1'b0;
                csum_next      = '0;
                ovf_next       = 1'b0;
                prev_pct_next  = 1'b0;
            end else begin
                if (!in_line_reg) begin
                    in_line_next   = 1'b1;
                    first_ok_next  = (s_data_byte == CH_LOWER_P)
                                     || (s_data_byte == CH_LOWER_S)
                                     || (s_data_byte == CH_PERCENT);
                    first_pct_next = (s_data_byte == CH_PERCENT);
                end
                if (byte_go) begin
                    csum_next     = csum_upd;
                    prev_pct_next = (s_data_byte == CH_PERCENT);
                    line_pos_next = line_pos_reg + LINE_POS_W'(1);
                end else if (!ovf_reg) begin
                    ovf_next = 1'b1;   // first byte past the limit
                end
            end
        end
    end

    // ---------------- keyword matchers ----------------
    always_comb begin
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            kw_prog_next[k]  = kw_prog_reg[k];
            kw_start_next[k] = kw_start_reg[k];
            kw_phase_next[k] = kw_phase_reg[k];
            kw_snap_next[k]  = kw_snap_reg[k];
            kw_wr_next[k]    = kw_wr_reg[k];
            kw_plp_next[k]   = kw_plp_reg[k];

            if (accept && (is_abort || is_term)) begin
                kw_prog_next[k]  = '0;
                kw_start_next[k] = '0;
                kw_phase_next[k] = PH_SCAN;
                kw_snap_next[k]  = '0;
                kw_wr_next[k]    = '0;
                kw_plp_next[k]   = 1'b0;
            end else if (accept && byte_go) begin
                case (kw_phase_reg[k])
                    PH_SCAN: begin
                        // naive restart: retest the byte against the first char
                        if ((s_data_byte == kw_char(k, kw_prog_reg[k]))
                            || (s_data_byte == kw_char(k, '0))) begin
                            if ((s_data_byte != kw_char(k, kw_prog_reg[k]))
                                || (kw_prog_reg[k] == '0)) begin
                                kw_start_next[k] = line_pos_reg[KW_START_W-1:0];
                                kw_plp_next[k]   = prev_pct_reg;
                                if (KW_LEN[k] == KW_IDX_W'(1)) begin
                                    kw_phase_next[k] = PH_FOLLOW;
                                    kw_prog_next[k]  = '0;
                                end else begin
                                    kw_prog_next[k] = KW_IDX_W'(1);
                                end
                            end else if (kw_prog_reg[k] + KW_IDX_W'(1) == KW_LEN[k]) begin
                                kw_phase_next[k] = PH_FOLLOW;
                                kw_prog_next[k]  = '0;
                            end else begin
                                kw_prog_next[k] = kw_prog_reg[k] + KW_IDX_W'(1);
                            end
                        end else begin
                            kw_prog_next[k] = '0;
                        end
                    end
                    PH_FOLLOW: begin
                        if (s_data_byte == CH_AT) begin
                            kw_snap_next[k]  = rotl2(csum_upd);
                            kw_phase_next[k] = PH_HEX1;
                        end else if ((s_data_byte == CH_SEMI) || (s_data_byte == CH_AMP)
                                     || (s_data_byte == CH_PIPE)
                                     || (s_data_byte == CH_SPACE)) begin
                            kw_phase_next[k] = PH_MATCH;
                        end else begin
                            kw_phase_next[k] = PH_FAIL;
                        end
                    end
                    PH_HEX1: begin
                        if (!hex_d[4]) begin
                            kw_wr_next[k]    = hex_d[3:0];
                            kw_phase_next[k] = PH_HEX2;
                        end else begin
                            kw_phase_next[k] = PH_HEX2_BAD;
                        end
                    end
                    PH_HEX2: begin
                        if (!hex_d[4] && ({kw_wr_reg[k], hex_d[3:0]} == kw_snap_reg[k])) begin
                            kw_phase_next[k] = PH_MATCH_CS;
                        end else if (hex_d[4] && (kw_snap_reg[k] == 8'hFF)) begin
                            kw_phase_next[k] = PH_MATCH_CS;
                        end else begin
                            kw_phase_next[k] = PH_FAIL;
                        end
                    end
                    PH_HEX2_BAD: begin
                        kw_phase_next[k] = (kw_snap_reg[k] == 8'hFF) ? PH_MATCH_CS : PH_FAIL;
                    end
                    default: begin
                        kw_phase_next[k] = kw_phase_reg[k];   // match or fail: held
                    end
                endcase
            end
        end
    end

    // settle open matchers at line end; a cut checksum reads as 0xFF
    always_comb begin
        for (int k = 0; k < KEYWORD_COUNT; k++) begin
            case (kw_phase_reg[k])
                PH_FOLLOW: kw_end_phase[k] = PH_MATCH;
                PH_HEX1, PH_HEX2, PH_HEX2_BAD: begin
                    kw_end_phase[k] = (kw_snap_reg[k] == 8'hFF) ? PH_MATCH_CS : PH_FAIL;
                end
                default: kw_end_phase[k] = kw_phase_reg[k];
            endcase
            kw_hit[k] = first_ok_reg && !ovf_reg
                        && ((kw_end_phase[k] == PH_MATCH) || (kw_end_phase[k] == PH_MATCH_CS));
        end
    end

    // lowest index wins
    always_comb begin
        hit_idx = CMD_NO_MATCH;
        hit_any = 1'b0;
        for (int k = KEYWORD_COUNT - 1; k >= 0; k--) begin
            if (kw_hit[k]) begin
                hit_idx = 3'(k);
                hit_any = 1'b1;
            end
        end
    end

    // ---------------- result word ----------------
    always_comb begin
        cmd_next  = CMD_NO_MATCH;
        cs_next   = 1'b0;
        pst_next  = PFX_NONE;
        plen_next = '0;
        hit_start = '0;
        if (hit_any) begin
            hit_start = kw_start_reg[hit_idx];
            cmd_next  = hit_idx;
            cs_next   = (kw_end_phase[hit_idx] == PH_MATCH_CS);
            if (hit_start == '0) begin
                pst_next = PFX_NONE;
            end else if (hit_start >= KW_START_W'(PREFIX_MAX)) begin
                pst_next = PFX_TOO_LONG;
            end else if (hit_start == KW_START_W'(1)) begin
                pst_next = PFX_TOO_SHORT;
            end else if (first_pct_reg && kw_plp_reg[hit_idx]) begin
                pst_next  = PFX_RECEIVED;
                plen_next = hit_start[4:0];
            end else begin
                pst_next = PFX_UNKNOWN;
            end
        end
    end

    // a held word stays until taken; bytes that close no line leave it alone
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept && emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_pos_reg  <= '0;
            in_line_reg   <= 1'b0;
            first_ok_reg  <= 1'b0;
            first_pct_reg <= 1'b0;
            csum_reg      <= '0;
            ovf_reg       <= 1'b0;
            prev_pct_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            for (int k = 0; k < KEYWORD_COUNT; k++) begin
                kw_prog_reg[k]  <= '0;
                kw_start_reg[k] <= '0;
                kw_phase_reg[k] <= PH_SCAN;
                kw_snap_reg[k]  <= '0;
                kw_wr_reg[k]    <= '0;
                kw_plp_reg[k]   <= 1'b0;
            end
        end else begin
            line_pos_reg  <= line_pos_next;
            in_line_reg   <= in_line_next;
            first_ok_reg  <= first_ok_next;
            first_pct_reg <= first_pct_next;
            csum_reg      <= csum_next;
            ovf_reg       <= ovf_next;
            prev_pct_reg  <= prev_pct_next;
            m_valid_reg   <= m_valid_next;
            for (int k = 0; k < KEYWORD_COUNT; k++) begin
                kw_prog_reg[k]  <= kw_prog_next[k];
                kw_start_reg[k] <= kw_start_next[k];
                kw_phase_reg[k] <= kw_phase_next[k];
                kw_snap_reg[k]  <= kw_snap_next[k];
                kw_wr_reg[k]    <= kw_wr_next[k];
                kw_plp_reg[k]   <= kw_plp_next[k];
            end
        end
    end

    // result payload, loaded with the terminator
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            cmd_reg  <= cmd_next;
            cs_reg   <= cs_next;
            pst_reg  <= pst_next;
            plen_reg <= plen_next;
            llen_reg <= 8'(line_pos_reg);
            lovf_reg <= ovf_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_command_index    = cmd_reg;
    assign m_checksum_present = cs_reg;
    assign m_prefix_status    = pst_reg;
    assign m_prefix_length    = plen_reg;
    assign m_line_length      = llen_reg;
    assign m_line_overflow    = lovf_reg;

endmodule
